FILE: rtl/core/lrupr_pkg.sv
// ----------------------------------------------------------------------------
// lrupr_pkg: shared types and constants for the LRU page replacement block
// Capacity register defaults, hit counter limits and the sequencer states.
// ----------------------------------------------------------------------------
package lrupr_pkg;

    localparam int unsigned DEF_MAX_ENTRIES = 8;
    localparam int unsigned DEF_PAGE_BITS   = 16;

    localparam int unsigned CAP_W = 4;
    localparam int unsigned HIT_W = 16;

    localparam logic [CAP_W-1:0] CAP_RESET = 4'd8;
    localparam logic [HIT_W-1:0] HITS_MAX  = 16'hFFFF;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_APPEND
    } t_state;

endpackage

FILE: rtl/core/lrupr_tag_ram.sv
// ----------------------------------------------------------------------------
// lrupr_tag_ram: recency-ordered tag store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lrupr_tag_ram
    import lrupr_pkg::*;
#(
    parameter int unsigned DEPTH = DEF_MAX_ENTRIES,
    parameter int unsigned WIDTH = DEF_PAGE_BITS,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/lru_page_replacement_top.sv
// ----------------------------------------------------------------------------
// lru_page_replacement_top: fully associative page cache with LRU replacement
// Sequential tag search and recency shift over a single-port-pair tag RAM.
// ----------------------------------------------------------------------------
// Input: hold i_page and i_last_of_run with i_start high; the transaction is
//   taken at a rising edge where i_start is high and o_busy is low.
// Output: one result per transaction (o_hit, o_hit_count, o_run_done), shown
//   for exactly one cycle with o_valid high. The receiver cannot stall, so
//   capture the result in that cycle.
// Configuration: pulse i_cfg_we with i_cfg_wdata to set the capacity, only
//   while o_busy is low and no transaction is in flight.
// Sequence: tags are walked oldest first through one shared comparator, each
//   with a RAM read step and a compare step, plus an end-of-list step on a miss.
//   Compaction then reads and writes each moved tag and ends with a closing
//   read, and one append step follows. A miss on a full list of MAX_ENTRIES
//   tags is the worst case; o_valid rises as o_busy falls, so a new
//   transaction can be taken while o_valid is high.
// Reset: clear occupancy, the hit counter and the sequencer; capacity returns
//   to eight. Tag RAM contents are not cleared: only entries below occupancy
//   are ever used.
// ----------------------------------------------------------------------------
module lru_page_replacement_top
    import lrupr_pkg::*;
#(
    parameter int unsigned MAX_ENTRIES = DEF_MAX_ENTRIES,
    parameter int unsigned PAGE_BITS   = DEF_PAGE_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    input  logic [PAGE_BITS-1:0] i_page,
    input  logic                 i_last_of_run,
    input  logic                 i_cfg_we,
    input  logic [CAP_W-1:0]     i_cfg_wdata,
    output logic                 o_valid,
    output logic                 o_hit,
    output logic [HIT_W-1:0]     o_hit_count,
    output logic                 o_run_done
);

    // Address width and count width (count must hold MAX_ENTRIES itself).
    localparam int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int unsigned EXT_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    // Control state
    t_state             r_state, n_state;
    logic [CAP_W-1:0]   r_cap;
    logic [CNT_W-1:0]   r_occ, n_occ;
    logic [HIT_W-1:0]   r_hits, n_hits;
    logic               r_valid, n_valid;

    // Working registers of the current transaction
    logic [PAGE_BITS-1:0] r_page, n_page;
    logic                 r_last, n_last;
    logic [CNT_W-1:0]     r_cap_eff, n_cap_eff;
    logic [CNT_W-1:0]     r_idx, n_idx;     // search pointer
    logic [CNT_W-1:0]     r_dst, n_dst;     // compaction destination
    logic [CNT_W-1:0]     r_off, n_off;     // compaction source offset
    logic [CNT_W-1:0]     r_end, n_end;     // append slot
    logic                 r_hit, n_hit;

    // Result registers
    logic             r_hit_out, n_hit_out;
    logic [HIT_W-1:0] r_count, n_count;
    logic             r_run_done, n_run_done;

    // Tag RAM port signals
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    logic [PAGE_BITS-1:0] mem_wdata;
    logic [IDX_W-1:0]     mem_raddr;
    logic [PAGE_BITS-1:0] mem_rdata;

    logic             accept;
    logic             tag_eq;
    logic [CNT_W-1:0] src;
    logic [EXT_W-1:0] cap_ext;
    logic [CNT_W-1:0] cap_eff;

    assign o_busy = (r_state != ST_IDLE);
    assign accept = i_start && !o_busy;

    // The one comparator, shared by every search step.
    assign tag_eq = (mem_rdata == r_page);

    // Compaction source: tag that slides into the destination slot.
    assign src = r_dst + r_off;

    // Clamp capacity into 1..MAX_ENTRIES.
    assign cap_ext = EXT_W'(r_cap);
    always_comb begin
        if (r_cap == '0) begin
            cap_eff = CNT_W'(1);
        end else if (cap_ext > EXT_W'(MAX_ENTRIES)) begin
            cap_eff = CNT_W'(MAX_ENTRIES);
        end else begin
            cap_eff = CNT_W'(cap_ext);
        end
    end

    lrupr_tag_ram #(
        .DEPTH (MAX_ENTRIES),
        .WIDTH (PAGE_BITS),
        .AW    (IDX_W)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_SRCH_RD;
                end
            end
            ST_SRCH_RD: begin
                n_state = (r_idx == r_occ) ? ST_SHIFT_RD : ST_SRCH_CMP;
            end
            ST_SRCH_CMP: begin
                n_state = tag_eq ? ST_SHIFT_RD : ST_SRCH_RD;
            end
            ST_SHIFT_RD: begin
                n_state = (r_dst == r_end) ? ST_APPEND : ST_SHIFT_WR;
            end
            ST_SHIFT_WR: begin
                n_state = ST_SHIFT_RD;
            end
            ST_APPEND: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Datapath and RAM control
    always_comb begin
        n_occ      = r_occ;
        n_hits     = r_hits;
        n_valid    = 1'b0;
        n_page     = r_page;
        n_last     = r_last;
        n_cap_eff  = r_cap_eff;
        n_idx      = r_idx;
        n_dst      = r_dst;
        n_off      = r_off;
        n_end      = r_end;
        n_hit      = r_hit;
        n_hit_out  = r_hit_out;
        n_count    = r_count;
        n_run_done = r_run_done;
        mem_we     = 1'b0;
        mem_waddr  = r_dst[IDX_W-1:0];
        mem_wdata  = mem_rdata;
        mem_raddr  = r_idx[IDX_W-1:0];
        case (r_state)
            ST_IDLE: begin
                // Capture the transaction and the capacity in force.
                if (accept) begin
                    n_page    = i_page;
                    n_last    = i_last_of_run;
                    n_cap_eff = cap_eff;
                    n_idx     = '0;
                    n_hit     = 1'b0;
                end
            end
            ST_SRCH_RD: begin
                // End of list reached: miss. At capacity, drop oldest tags to make room.
                if (r_idx == r_occ) begin
                    if (r_occ >= r_cap_eff) begin
                        n_dst = '0;
                        n_off = r_occ - r_cap_eff + CNT_W'(1);
                        n_end = r_cap_eff - CNT_W'(1);
                    end else begin
                        n_dst = r_occ;
                        n_off = '0;
                        n_end = r_occ;
                    end
                end
            end
            ST_SRCH_CMP: begin
                if (tag_eq) begin
                    // Hit: close the gap and move the tag to the newest end.
                    n_hit = 1'b1;
                    n_dst = r_idx;
                    n_off = CNT_W'(1);
                    n_end = r_occ - CNT_W'(1);
                end else begin
                    n_idx = r_idx + CNT_W'(1);
                end
            end
            ST_SHIFT_RD: begin
                mem_raddr = src[IDX_W-1:0];
            end
            ST_SHIFT_WR: begin
                mem_we = 1'b1;
                n_dst  = r_dst + CNT_W'(1);
            end
            ST_APPEND: begin
                mem_we    = 1'b1;
                mem_waddr = r_end[IDX_W-1:0];
                mem_wdata = r_page;
                n_occ     = r_end + CNT_W'(1);
                if (r_hit && (r_hits != HITS_MAX)) begin
                    n_hits = r_hits + HIT_W'(1);
                end
                n_valid    = 1'b1;
                n_hit_out  = r_hit;
                n_count    = n_hits;
                n_run_done = r_last;
                // End of run: drop all tags and the counter.
                if (r_last) begin
                    n_occ  = '0;
                    n_hits = '0;
                end
            end
            default: begin
                n_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cap   <= CAP_RESET;
            r_occ   <= '0;
            r_hits  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_occ   <= n_occ;
            r_hits  <= n_hits;
            r_valid <= n_valid;
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_page     <= n_page;
        r_last     <= n_last;
        r_cap_eff  <= n_cap_eff;
        r_idx      <= n_idx;
        r_dst      <= n_dst;
        r_off      <= n_off;
        r_end      <= n_end;
        r_hit      <= n_hit;
        r_hit_out  <= n_hit_out;
        r_count    <= n_count;
        r_run_done <= n_run_done;
    end

    assign o_valid     = r_valid;
    assign o_hit       = r_hit_out;
    assign o_hit_count = r_count;
    assign o_run_done  = r_run_done;

    // A result only ever follows the append step.
    a_valid_after_append: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == ST_APPEND)
    ) else $error("result strobe without append step");

    // Occupancy never exceeds the tag store.
    a_occ_bound: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= CNT_W'(MAX_ENTRIES)
    ) else $error("occupancy beyond tag store depth");

    // The end of a run leaves an empty cache and a cleared counter.
    a_run_clear: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_run_done) |-> (r_occ == '0 && r_hits == '0)
    ) else $error("state not cleared after end of run");

    // An accepted transaction holds the block busy on the next cycle.
    a_busy_after_accept: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy
    ) else $error("accepted transaction did not raise busy");

endmodule
